[hdl/psch_pkg.sv]
// ---------------------------------------------------------------------------
// Preemptive scheduler package
// Shared codes, state encodings and the structs that travel between the
// controller and the task and network cells.
// ---------------------------------------------------------------------------
`default_nettype none

package psch_pkg;

	// Command codes of a request.
	localparam logic [1:0] CMD_TICK_BEGIN = 2'd0;
	localparam logic [1:0] CMD_ACTIVATE   = 2'd1;
	localparam logic [1:0] CMD_TICK_END   = 2'd2;

	// Task state encodings.
	localparam logic [2:0] ST_IDLE      = 3'd0;
	localparam logic [2:0] ST_RELEASED  = 3'd1;
	localparam logic [2:0] ST_RUNNING   = 3'd2;
	localparam logic [2:0] ST_PREEMPTED = 3'd3;
	localparam logic [2:0] ST_COMPLETED = 3'd4;

	// Configuration register indexes.
	localparam logic [2:0] REG_EXEC     = 3'd0;
	localparam logic [2:0] REG_PERIOD   = 3'd1;
	localparam logic [2:0] REG_SC_DELAY = 3'd2;
	localparam logic [2:0] REG_CA_DELAY = 3'd3;
	localparam logic [2:0] REG_CORES    = 3'd4;
	localparam logic [2:0] REG_SENSOR   = 3'd5;
	localparam logic [2:0] REG_ACTUATOR = 3'd6;
	localparam logic [2:0] REG_RUN_LEN  = 3'd7;

	localparam logic [15:0] INIT_PRIORITY = 16'd1000;
	localparam int          DEF_VEHICLES  = 4;
	localparam int          DEF_TIME_BITS = 16;

	// Command to one task cell.
	typedef struct packed {
		logic        tick;
		logic        ff;
		logic        start;
		logic        preempt;
		logic        clear;
		logic [15:0] prio;
	} tcmd_t;

	// Status of one task cell.
	typedef struct packed {
		logic [2:0] state;
		logic       act_flag;
		logic       done_flag;
		logic       comp_now;
		logic       rel_now;
	} tstat_t;

	// Worst running task seen so far along the chain.
	typedef struct packed {
		logic        found;
		logic [15:0] prio;
		logic [3:0]  idx;
	} carry_t;

	// Command to one network delay cell.
	typedef struct packed {
		logic tick;
		logic tb_start;
		logic te_start;
	} ncmd_t;

endpackage

`default_nettype wire

[hdl/preemptive_multicore_task_scheduler_top.sv]
// Tick_begin, and activate with a free core, give their registered result in the cycle after start.
// Activate without a free core walks the registered task cell chain in the search state, then gives its result.
// Tick_end waits on the remainder unit, applies its update in the apply state, then gives its
// first result from the emit state; the other VEHICLES-1 follow back to back.
// One request at a time; busy is high until its last result is out. Results cannot be stalled.
// Asynchronous reset puts all task, timer and counter state to its reset value at once; no clearing pass.
// ---------------------------------------------------------------------------
// Preemptive multicore task scheduler
// Fixed-priority preemptive scheduler over a chain of task cells with
// network delay cells and a sequencing controller.
// ---------------------------------------------------------------------------
`default_nettype none

module preemptive_multicore_task_scheduler_top #(
	parameter int VEHICLES  = psch_pkg::DEF_VEHICLES,
	parameter int TIME_BITS = psch_pkg::DEF_TIME_BITS
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [63:0] cfg_data,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [1:0]  command,
	input  wire logic [3:0]  task_req,
	input  wire logic [15:0] priority_req,
	input  wire logic [3:0]  ff_ref_mask,
	output logic             done,
	output logic             ok,
	output logic [15:0]      released_mask,
	output logic [15:0]      completed_mask,
	output logic             preempt_valid,
	output logic [3:0]       preempted_task,
	output logic [1:0]       vehicle,
	output logic [15:0]      trigger_bits,
	output logic             last,
	output logic [47:0]      task_states,
	output logic [4:0]       free_cores
);

	localparam int NTASK  = VEHICLES * 4;
	localparam int TIDX_W = $clog2(NTASK);
	localparam int CNT_W  = $clog2(NTASK + 1);

	typedef enum logic [2:0] {
		S_IDLE,
		S_SEARCH,
		S_MOD,
		S_TE_APPLY,
		S_EMIT
	} state_t;

	// Configuration registers.
	logic [63:0] exec_q;
	logic [63:0] period_q;
	logic [15:0] sc_q;
	logic [15:0] ca_q;
	logic [15:0] sensor_q;
	logic [15:0] actuator_q;
	logic [31:0] run_len_q;

	logic [4:0]  free_q;
	logic [31:0] step_q;
	state_t      state_q;
	logic [CNT_W-1:0] cnt_q;
	logic [1:0]  veh_q;
	logic [3:0]  req_task_q;
	logic [15:0] req_prio_q;
	logic [15:0] bits_q [VEHICLES];

	logic        done_q;
	logic        ok_q;
	logic [15:0] rel_q;
	logic [15:0] comp_q;
	logic        pv_q;
	logic [3:0]  pt_q;
	logic [1:0]  vout_q;
	logic [15:0] trig_q;
	logic        last_q;

	logic [TIME_BITS-1:0] exec_k   [4];
	logic [TIME_BITS-1:0] period_k [4];
	logic [TIME_BITS-1:0] sc_d;
	logic [TIME_BITS-1:0] ca_d;
	logic [31:0] sc32;
	logic [31:0] ca32;
	logic [63:0] period_src;

	psch_pkg::tcmd_t  tcmd   [NTASK];
	psch_pkg::tstat_t tstat  [NTASK];
	psch_pkg::carry_t carry  [NTASK+1];
	psch_pkg::ncmd_t  sc_cmd [VEHICLES];
	psch_pkg::ncmd_t  ca_cmd [VEHICLES];
	logic             sc_pulse [VEHICLES];
	logic             ca_pulse [VEHICLES];

	logic        accept;
	logic        finished;
	logic        tb_go;
	logic        in_range;
	logic [2:0]  sel_state;
	logic        act_valid;
	logic        act_free;
	logic        act_search;
	logic        search_end;
	logic        pre_go;
	logic        te_apply;
	logic        period_load;
	logic [15:0] comp_mask;
	logic [15:0] rel_mask;
	logic [4:0]  comp_cnt;
	logic [5:0]  free_sum;
	logic        mod_done;
	logic        sfire;
	logic        afire;
	logic [15:0] sp_div;
	logic [15:0] ap_div;
	logic [15:0] bits_nx [VEHICLES];

	// A period write loads the timers with the periods being written.
	assign period_src = period_load ? cfg_data : period_q;

	// Time fields trimmed to the timer width.
	for (genvar k = 0; k < 4; k++) begin : g_fields
		logic [31:0] ex32;
		logic [31:0] pe32;
		assign ex32        = {16'b0, exec_q[16*k +: 16]};
		assign pe32        = {16'b0, period_src[16*k +: 16]};
		assign exec_k[k]   = ex32[TIME_BITS-1:0];
		assign period_k[k] = pe32[TIME_BITS-1:0];
	end
	assign sc32 = {16'b0, sc_q};
	assign ca32 = {16'b0, ca_q};
	assign sc_d = sc32[TIME_BITS-1:0];
	assign ca_d = ca32[TIME_BITS-1:0];

	// Request decode.
	assign busy      = (state_q != S_IDLE);
	assign accept    = start && !busy;
	assign finished  = (step_q >= run_len_q);
	assign tb_go     = accept && command == psch_pkg::CMD_TICK_BEGIN && !finished;
	assign in_range  = ({1'b0, task_req} < 5'(NTASK));
	assign sel_state = in_range ? tstat[task_req[TIDX_W-1:0]].state : psch_pkg::ST_IDLE;
	assign act_valid = in_range && (sel_state == psch_pkg::ST_RELEASED ||
		sel_state == psch_pkg::ST_PREEMPTED);
	assign act_free   = accept && command == psch_pkg::CMD_ACTIVATE && act_valid &&
		free_q != '0;
	assign act_search = accept && command == psch_pkg::CMD_ACTIVATE && act_valid &&
		free_q == '0;
	assign search_end = (state_q == S_SEARCH) && (cnt_q == CNT_W'(NTASK));
	assign pre_go     = search_end && carry[NTASK].found && req_prio_q < carry[NTASK].prio;
	assign te_apply   = (state_q == S_TE_APPLY);
	assign period_load = cfg_we && cfg_index == psch_pkg::REG_PERIOD;

	// Per-cell commands.
	always_comb begin
		for (int t = 0; t < NTASK; t++) begin
			tcmd[t].tick    = tb_go;
			tcmd[t].ff      = ff_ref_mask[t/4] && ((t % 4) >= 2);
			tcmd[t].start   = (act_free && task_req[TIDX_W-1:0] == TIDX_W'(t)) ||
				(pre_go && req_task_q[TIDX_W-1:0] == TIDX_W'(t));
			tcmd[t].preempt = pre_go && carry[NTASK].idx == 4'(t);
			tcmd[t].clear   = te_apply;
			tcmd[t].prio    = act_free ? priority_req : req_prio_q;
		end
	end

	// Task cell chain.
	assign carry[0] = '0;
	for (genvar t = 0; t < NTASK; t++) begin : g_task
		psch_task_cell #(
			.TIME_BITS (TIME_BITS),
			.INDEX     (t)
		) u_cell (
			.clk          (clk),
			.arst_n       (arst_n),
			.exec_ticks   (exec_k[t % 4]),
			.period_ticks (period_k[t % 4]),
			.period_load  (period_load),
			.cmd          (tcmd[t]),
			.carry_in     (carry[t]),
			.carry_out    (carry[t+1]),
			.status       (tstat[t])
		);
	end

	// Visible state and tick masks.
	for (genvar t = 0; t < 16; t++) begin : g_view
		if (t < NTASK) begin : g_on
			assign task_states[3*t +: 3] = tstat[t].state;
			assign comp_mask[t]          = tstat[t].comp_now;
			assign rel_mask[t]           = tstat[t].rel_now;
		end else begin : g_off
			assign task_states[3*t +: 3] = psch_pkg::ST_IDLE;
			assign comp_mask[t]          = 1'b0;
			assign rel_mask[t]           = 1'b0;
		end
	end

	// Network delay cells, sensor-to-controller and controller-to-actuator.
	for (genvar v = 0; v < VEHICLES; v++) begin : g_net
		assign sc_cmd[v] = '{tick: tb_go, tb_start: 1'b0, te_start: te_apply && sfire};
		assign ca_cmd[v] = '{tick: tb_go, tb_start: tstat[v*4+3].comp_now, te_start: 1'b0};
		psch_net_cell #(.TIME_BITS(TIME_BITS)) u_sc (
			.clk         (clk),
			.arst_n      (arst_n),
			.delay_ticks (sc_d),
			.cmd         (sc_cmd[v]),
			.pulse       (sc_pulse[v])
		);
		psch_net_cell #(.TIME_BITS(TIME_BITS)) u_ca (
			.clk         (clk),
			.arst_n      (arst_n),
			.delay_ticks (ca_d),
			.cmd         (ca_cmd[v]),
			.pulse       (ca_pulse[v])
		);
	end

	// Sensor and actuator phase from the tick count.
	assign sp_div = (sensor_q == '0) ? 16'd1 : sensor_q;
	assign ap_div = (actuator_q == '0) ? 16'd1 : actuator_q;
	psch_mod_unit u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (accept && command == psch_pkg::CMD_TICK_END),
		.dividend (step_q),
		.div_a    (sp_div),
		.div_b    (ap_div),
		.done     (mod_done),
		.zero_a   (sfire),
		.zero_b   (afire)
	);

	// Completed tasks hand back their cores.
	always_comb begin
		comp_cnt = '0;
		for (int t = 0; t < 16; t++) begin
			comp_cnt = comp_cnt + 5'(comp_mask[t]);
		end
		free_sum = {1'b0, free_q} + {1'b0, comp_cnt};
	end

	// Trigger vectors from the state before completed tasks go idle.
	always_comb begin
		for (int v = 0; v < VEHICLES; v++) begin
			bits_nx[v] = '0;
			if (sfire) begin
				bits_nx[v][2:0] = 3'b111;
			end
			bits_nx[v][3] = sc_pulse[v];
			for (int k = 0; k < 4; k++) begin
				bits_nx[v][4+2*k] = tstat[v*4+k].act_flag;
				bits_nx[v][5+2*k] = tstat[v*4+k].done_flag;
			end
			bits_nx[v][12] = tstat[v*4+3].done_flag;
			bits_nx[v][13] = ca_pulse[v];
			if (afire) begin
				bits_nx[v][15:14] = 2'b11;
			end
		end
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exec_q     <= '0;
			period_q   <= '0;
			sc_q       <= 16'd1;
			ca_q       <= 16'd1;
			sensor_q   <= 16'd1;
			actuator_q <= 16'd1;
			run_len_q  <= '1;
		end else if (cfg_we) begin
			case (cfg_index)
				psch_pkg::REG_EXEC:     exec_q     <= cfg_data;
				psch_pkg::REG_PERIOD:   period_q   <= cfg_data;
				psch_pkg::REG_SC_DELAY: sc_q       <= cfg_data[15:0];
				psch_pkg::REG_CA_DELAY: ca_q       <= cfg_data[15:0];
				psch_pkg::REG_SENSOR:   sensor_q   <= cfg_data[15:0];
				psch_pkg::REG_ACTUATOR: actuator_q <= cfg_data[15:0];
				psch_pkg::REG_RUN_LEN:  run_len_q  <= cfg_data[31:0];
				default: begin
				end
			endcase
		end
	end

	// Controller: sequencing, counters and registered results.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			free_q     <= 5'd2;
			step_q     <= '0;
			cnt_q      <= '0;
			veh_q      <= '0;
			req_task_q <= '0;
			req_prio_q <= '0;
			done_q     <= 1'b0;
			ok_q       <= 1'b0;
			rel_q      <= '0;
			comp_q     <= '0;
			pv_q       <= 1'b0;
			pt_q       <= '0;
			vout_q     <= '0;
			trig_q     <= '0;
			last_q     <= 1'b0;
			for (int v = 0; v < VEHICLES; v++) begin
				bits_q[v] <= '0;
			end
		end else begin
			done_q <= 1'b0;
			ok_q   <= 1'b0;
			rel_q  <= '0;
			comp_q <= '0;
			pv_q   <= 1'b0;
			pt_q   <= '0;
			vout_q <= '0;
			trig_q <= '0;
			last_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						req_task_q <= task_req;
						req_prio_q <= priority_req;
						case (command)
							psch_pkg::CMD_TICK_BEGIN: begin
								done_q <= 1'b1;
								last_q <= 1'b1;
								if (!finished) begin
									ok_q   <= 1'b1;
									rel_q  <= rel_mask;
									comp_q <= comp_mask;
									free_q <= (free_sum > 6'd31) ? 5'd31 : free_sum[4:0];
								end
							end
							psch_pkg::CMD_ACTIVATE: begin
								if (act_search) begin
									state_q <= S_SEARCH;
									cnt_q   <= '0;
								end else begin
									done_q <= 1'b1;
									last_q <= 1'b1;
									if (act_free) begin
										ok_q   <= 1'b1;
										free_q <= free_q - 1'b1;
									end
								end
							end
							psch_pkg::CMD_TICK_END: begin
								state_q <= S_MOD;
							end
							default: begin
							end
						endcase
					end
				end
				S_SEARCH: begin
					cnt_q <= cnt_q + 1'b1;
					if (search_end) begin
						state_q <= S_IDLE;
						done_q  <= 1'b1;
						last_q  <= 1'b1;
						if (pre_go) begin
							ok_q <= 1'b1;
							pv_q <= 1'b1;
							pt_q <= carry[NTASK].idx;
						end
					end
				end
				S_MOD: begin
					if (mod_done) begin
						state_q <= S_TE_APPLY;
					end
				end
				S_TE_APPLY: begin
					for (int v = 0; v < VEHICLES; v++) begin
						bits_q[v] <= bits_nx[v];
					end
					if (step_q != '1) begin
						step_q <= step_q + 1'b1;
					end
					veh_q   <= '0;
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					done_q <= 1'b1;
					vout_q <= veh_q;
					trig_q <= bits_q[veh_q];
					veh_q  <= veh_q + 1'b1;
					if (veh_q == 2'(VEHICLES - 1)) begin
						last_q  <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			if (cfg_we && cfg_index == psch_pkg::REG_CORES) begin
				free_q <= cfg_data[4:0];
			end
		end
	end

	assign done           = done_q;
	assign ok             = ok_q;
	assign released_mask  = rel_q;
	assign completed_mask = comp_q;
	assign preempt_valid  = pv_q;
	assign preempted_task = pt_q;
	assign vehicle        = vout_q;
	assign trigger_bits   = trig_q;
	assign last           = last_q;
	assign free_cores     = free_q;

`ifndef SYNTH
	// A preemption is always a successful activation.
	a_preempt_ok: assert property (@(posedge clk) disable iff (!arst_n)
		done && preempt_valid |-> ok)
		else $error("preemption reported without ok");

	// Releases are only reported by a tick that ran.
	a_rel_ok: assert property (@(posedge clk) disable iff (!arst_n)
		done && released_mask != '0 |-> ok && last)
		else $error("release mask on a failed result");

	// Tick_end results follow one another without gaps.
	a_emit_run: assert property (@(posedge clk) disable iff (!arst_n)
		done && !last |=> done)
		else $error("gap inside a tick_end burst");

	// A tick_end request keeps the block busy.
	a_te_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && command == psch_pkg::CMD_TICK_END |=> busy)
		else $error("tick_end did not start the sequence");
`endif

endmodule

`default_nettype wire

[hdl/psch_task_cell.sv]
// ---------------------------------------------------------------------------
// Task cell
// Holds state, remaining run ticks, priority and period timer of one task,
// and passes the worst running task found so far to its neighbor.
// ---------------------------------------------------------------------------
`default_nettype none

module psch_task_cell #(
	parameter int TIME_BITS = psch_pkg::DEF_TIME_BITS,
	parameter int INDEX     = 0
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic [TIME_BITS-1:0] exec_ticks,
	input  wire logic [TIME_BITS-1:0] period_ticks,
	input  wire logic                 period_load,
	input  wire psch_pkg::tcmd_t      cmd,
	input  wire psch_pkg::carry_t     carry_in,
	output psch_pkg::carry_t          carry_out,
	output psch_pkg::tstat_t          status
);

	localparam logic [TIME_BITS-1:0] TMASK = '1;
	localparam logic [3:0]           IDX   = 4'(INDEX);

	logic [2:0]           st_q;
	logic [TIME_BITS-1:0] rem_q;
	logic [15:0]          prio_q;
	logic [TIME_BITS-1:0] tmr_q;
	psch_pkg::carry_t     carry_q;

	logic [2:0]           st_tb;
	logic [TIME_BITS-1:0] rem_tb;
	logic [TIME_BITS-1:0] tmr_tb;
	logic                 comp_tb;
	logic                 rel_tb;

	// Next state for a tick: charge, periodic release, feedforward release.
	always_comb begin
		st_tb   = st_q;
		rem_tb  = rem_q;
		tmr_tb  = tmr_q;
		comp_tb = 1'b0;
		rel_tb  = 1'b0;
		if (st_q == psch_pkg::ST_RUNNING) begin
			if (rem_q <= TIME_BITS'(1)) begin
				st_tb   = psch_pkg::ST_COMPLETED;
				rem_tb  = '0;
				comp_tb = 1'b1;
			end else begin
				rem_tb = rem_q - 1'b1;
			end
		end
		if (tmr_q != TMASK) begin
			tmr_tb = tmr_q + 1'b1;
		end
		if (period_ticks != '0 && tmr_tb >= period_ticks) begin
			tmr_tb = '0;
			if (st_tb == psch_pkg::ST_IDLE) begin
				st_tb  = psch_pkg::ST_RELEASED;
				rel_tb = 1'b1;
			end
		end
		if (cmd.ff && st_tb == psch_pkg::ST_IDLE) begin
			st_tb  = psch_pkg::ST_RELEASED;
			tmr_tb = '0;
			rel_tb = 1'b1;
		end
	end

	// Task registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= psch_pkg::ST_IDLE;
			rem_q  <= '0;
			prio_q <= psch_pkg::INIT_PRIORITY;
			tmr_q  <= '0;
		end else begin
			if (cmd.tick) begin
				st_q  <= st_tb;
				rem_q <= rem_tb;
				tmr_q <= tmr_tb;
			end else if (cmd.start) begin
				st_q   <= psch_pkg::ST_RUNNING;
				prio_q <= cmd.prio;
				if (rem_q == '0) begin
					rem_q <= exec_ticks;
				end
			end else if (cmd.preempt) begin
				st_q <= psch_pkg::ST_PREEMPTED;
			end else if (cmd.clear && st_q == psch_pkg::ST_COMPLETED) begin
				st_q <= psch_pkg::ST_IDLE;
			end
			if (period_load) begin
				tmr_q <= period_ticks;
			end
		end
	end

	// Worst-priority chain stage; ties keep the lower index.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			carry_q <= '0;
		end else begin
			if (st_q == psch_pkg::ST_RUNNING && (!carry_in.found || prio_q > carry_in.prio)) begin
				carry_q <= '{found: 1'b1, prio: prio_q, idx: IDX};
			end else begin
				carry_q <= carry_in;
			end
		end
	end

	assign carry_out        = carry_q;
	assign status.state     = st_q;
	assign status.act_flag  = (st_q == psch_pkg::ST_RUNNING && rem_q == exec_ticks) ||
		(st_q == psch_pkg::ST_COMPLETED && exec_ticks == '0);
	assign status.done_flag = (st_q == psch_pkg::ST_COMPLETED);
	assign status.comp_now  = comp_tb;
	assign status.rel_now   = rel_tb;

endmodule

`default_nettype wire

[hdl/psch_net_cell.sv]
// ---------------------------------------------------------------------------
// Network delay cell
// Counts down one network delay in ticks and flags its arrival.
// ---------------------------------------------------------------------------
`default_nettype none

module psch_net_cell #(
	parameter int TIME_BITS = psch_pkg::DEF_TIME_BITS
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic [TIME_BITS-1:0] delay_ticks,
	input  wire psch_pkg::ncmd_t      cmd,
	output logic                      pulse
);

	logic                 act_q;
	logic [TIME_BITS-1:0] rem_q;
	logic                 pulse_q;

	logic                 act_nx;
	logic [TIME_BITS-1:0] rem_nx;
	logic                 pulse_nx;

	// Tick: optional start, then one count.
	always_comb begin
		act_nx   = act_q;
		rem_nx   = rem_q;
		pulse_nx = 1'b0;
		if (cmd.tb_start && !act_q) begin
			act_nx = 1'b1;
			rem_nx = delay_ticks;
		end
		if (act_nx) begin
			if (rem_nx <= TIME_BITS'(1)) begin
				rem_nx   = '0;
				act_nx   = 1'b0;
				pulse_nx = 1'b1;
			end else begin
				rem_nx = rem_nx - 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q   <= 1'b0;
			rem_q   <= '0;
			pulse_q <= 1'b0;
		end else begin
			if (cmd.tick) begin
				act_q   <= act_nx;
				rem_q   <= rem_nx;
				pulse_q <= pulse_nx;
			end else if (cmd.te_start && !act_q) begin
				act_q <= 1'b1;
				rem_q <= delay_ticks;
			end
		end
	end

	assign pulse = pulse_q;

endmodule

`default_nettype wire

[hdl/psch_mod_unit.sv]
// ---------------------------------------------------------------------------
// Remainder unit
// Restoring division, one bit a cycle, giving whether the tick count is a
// multiple of the sensor and of the actuator period.
// ---------------------------------------------------------------------------
`default_nettype none

module psch_mod_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        go,
	input  wire logic [31:0] dividend,
	input  wire logic [15:0] div_a,
	input  wire logic [15:0] div_b,
	output logic             done,
	output logic             zero_a,
	output logic             zero_b
);

	logic [31:0] q_q;
	logic [15:0] ra_q;
	logic [15:0] rb_q;
	logic [5:0]  cnt_q;
	logic        run_q;
	logic        done_q;

	logic [16:0] sa;
	logic [16:0] sb;
	logic [16:0] na;
	logic [16:0] nb;

	// One restoring step for each divisor.
	always_comb begin
		sa = {ra_q, q_q[31]};
		sb = {rb_q, q_q[31]};
		na = (sa >= {1'b0, div_a}) ? sa - {1'b0, div_a} : sa;
		nb = (sb >= {1'b0, div_b}) ? sb - {1'b0, div_b} : sb;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			q_q    <= '0;
			ra_q   <= '0;
			rb_q   <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				run_q <= 1'b1;
				cnt_q <= '0;
				q_q   <= dividend;
				ra_q  <= '0;
				rb_q  <= '0;
			end else if (run_q) begin
				q_q   <= {q_q[30:0], 1'b0};
				ra_q  <= na[15:0];
				rb_q  <= nb[15:0];
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == 6'd31) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done   = done_q;
	assign zero_a = (ra_q == '0);
	assign zero_b = (rb_q == '0);

endmodule

`default_nettype wire

[test/tb_preemptive_multicore_task_scheduler_top.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Preemptive multicore task scheduler testbench
// Drives tick_begin, activate and tick_end requests through the command
// handshake, keeps its own model of the task table, network timers and core
// pool, and compares every result strobe field by field, in order.
// ---------------------------------------------------------------------------
`default_nettype none

module tb_preemptive_multicore_task_scheduler_top;

	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int SETTLE_CYCLES  = 60;

	// One result of the block.
	typedef struct packed {
		logic        ok;
		logic [15:0] released;
		logic [15:0] completed;
		logic        pv;
		logic [3:0]  pt;
		logic [1:0]  veh;
		logic [15:0] trig;
		logic        last;
		logic [47:0] states;
		logic [4:0]  free;
	} sched_result_t;

	// One row of the directed table.
	typedef struct {
		logic [1:0]    cmd;
		logic [3:0]    tsk;
		logic [15:0]   prio;
		logic [3:0]    ff;
		bit            typed;
		sched_result_t want;
	} plan_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [2:0]  cfg_index = '0;
	logic [63:0] cfg_data = '0;
	logic        start = 1'b0;
	logic [1:0]  command = '0;
	logic [3:0]  task_req = '0;
	logic [15:0] priority_req = '0;
	logic [3:0]  ff_ref_mask = '0;
	logic        busy, done, ok, preempt_valid, last;
	logic [15:0] released_mask, completed_mask, trigger_bits;
	logic [3:0]  preempted_task;
	logic [1:0]  vehicle;
	logic [47:0] task_states;
	logic [4:0]  free_cores;

	preemptive_multicore_task_scheduler_top dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .start(start), .busy(busy), .command(command),
		.task_req(task_req), .priority_req(priority_req), .ff_ref_mask(ff_ref_mask),
		.done(done), .ok(ok), .released_mask(released_mask),
		.completed_mask(completed_mask), .preempt_valid(preempt_valid),
		.preempted_task(preempted_task), .vehicle(vehicle),
		.trigger_bits(trigger_bits), .last(last), .task_states(task_states),
		.free_cores(free_cores)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	// Scheduler model: configuration and state.
	logic [63:0] m_exec, m_period;
	logic [15:0] m_sc, m_ca, m_sens, m_act;
	logic [4:0]  m_cores;
	logic [31:0] m_runlen, m_steps;
	logic [2:0]  m_state [16];
	logic [15:0] m_remain [16];
	logic [15:0] m_prio [16];
	logic [15:0] m_timer [16];
	bit          m_nact [8];
	logic [15:0] m_nrem [8];
	bit          m_npulse [8];
	logic [4:0]  m_free;

	sched_result_t pending_results [$];
	int mismatches = 0;
	int results_seen = 0;
	int items_sent = 0;
	int idle_cycles = 0;
	bit item_taken = 1'b0;

	function automatic logic [15:0] exec_ticks(int k);
		return m_exec[16*k +: 16];
	endfunction

	function automatic logic [15:0] period_ticks(int k);
		return m_period[16*k +: 16];
	endfunction

	function automatic void model_reset();
		m_exec = '0; m_period = '0; m_sc = 16'd1; m_ca = 16'd1; m_cores = 5'd2;
		m_sens = 16'd1; m_act = 16'd1; m_runlen = 32'hFFFF_FFFF;
		for (int t = 0; t < 16; t++) begin
			m_state[t] = psch_pkg::ST_IDLE; m_remain[t] = '0;
			m_prio[t] = psch_pkg::INIT_PRIORITY;
			m_timer[t] = '0;
		end
		for (int n = 0; n < 8; n++) begin
			m_nact[n] = 0; m_nrem[n] = '0; m_npulse[n] = 0;
		end
		m_free = m_cores;
		m_steps = '0;
	endfunction

	function automatic void model_write(logic [2:0] idx, logic [63:0] val);
		case (idx)
			psch_pkg::REG_EXEC: m_exec = val;
			psch_pkg::REG_PERIOD: begin
				m_period = val;
				for (int t = 0; t < 16; t++) m_timer[t] = period_ticks(t % 4);
			end
			psch_pkg::REG_SC_DELAY: m_sc = val[15:0];
			psch_pkg::REG_CA_DELAY: m_ca = val[15:0];
			psch_pkg::REG_CORES: begin
				m_cores = val[4:0];
				m_free = val[4:0];
			end
			psch_pkg::REG_SENSOR: m_sens = val[15:0];
			psch_pkg::REG_ACTUATOR: m_act = val[15:0];
			default: m_runlen = val[31:0];
		endcase
	endfunction

	function automatic void push_result(logic okv, logic [15:0] rel, logic [15:0] comp,
			logic pv, logic [3:0] pt, logic [1:0] veh, logic [15:0] trig, logic lst);
		sched_result_t r;
		r.ok = okv; r.released = rel; r.completed = comp; r.pv = pv; r.pt = pt;
		r.veh = veh; r.trig = trig; r.last = lst; r.free = m_free;
		for (int t = 0; t < 16; t++) r.states[3*t +: 3] = m_state[t];
		pending_results.insert(pending_results.size(), r);
	endfunction

	function automatic void net_countdown(int n);
		if (m_nact[n]) begin
			if (m_nrem[n] <= 1) begin
				m_nrem[n] = '0; m_nact[n] = 0; m_npulse[n] = 1;
			end else begin
				m_nrem[n]--;
			end
		end
	endfunction

	function automatic void model_tick_begin(logic [3:0] ff);
		logic [15:0] rel, comp, p;
		int t;
		rel = '0; comp = '0;
		if (m_steps >= m_runlen) begin
			push_result(0, 0, 0, 0, 0, 0, 0, 1);
			return;
		end
		for (int n = 0; n < 8; n++) m_npulse[n] = 0;
		// Charge running tasks and free the cores of those that finish.
		for (t = 0; t < 16; t++) begin
			if (m_state[t] == psch_pkg::ST_RUNNING) begin
				if (m_remain[t] <= 1) begin
					m_state[t] = psch_pkg::ST_COMPLETED; m_remain[t] = '0; comp[t] = 1'b1;
					if (m_free < 31) m_free++;
					if (t % 4 == 3 && !m_nact[4 + t/4]) begin
						m_nact[4 + t/4] = 1; m_nrem[4 + t/4] = m_ca;
					end
				end else begin
					m_remain[t]--;
				end
			end
		end
		for (int v = 0; v < 4; v++) begin
			net_countdown(v);
			net_countdown(4 + v);
		end
		// Periodic releases.
		for (t = 0; t < 16; t++) begin
			p = period_ticks(t % 4);
			if (m_timer[t] < 16'hFFFF) m_timer[t]++;
			if (p > 0 && m_timer[t] >= p) begin
				m_timer[t] = '0;
				if (m_state[t] == psch_pkg::ST_IDLE) begin
					m_state[t] = psch_pkg::ST_RELEASED; rel[t] = 1'b1;
				end
			end
		end
		// Feedforward reference releases the feedforward and merger tasks.
		for (int v = 0; v < 4; v++) begin
			if (ff[v]) begin
				for (int k = 2; k < 4; k++) begin
					t = v*4 + k;
					if (m_state[t] == psch_pkg::ST_IDLE) begin
						m_state[t] = psch_pkg::ST_RELEASED; m_timer[t] = '0; rel[t] = 1'b1;
					end
				end
			end
		end
		push_result(1, rel, comp, 0, 0, 0, 0, 1);
	endfunction

	function automatic void model_run(int t, logic [15:0] pr);
		m_state[t] = psch_pkg::ST_RUNNING;
		m_prio[t] = pr;
		if (m_remain[t] == 0) m_remain[t] = exec_ticks(t % 4);
	endfunction

	function automatic void model_activate(int t, logic [15:0] pr);
		int worst;
		bit found;
		worst = 0; found = 0;
		if (m_state[t] != psch_pkg::ST_RELEASED && m_state[t] != psch_pkg::ST_PREEMPTED) begin
			push_result(0, 0, 0, 0, 0, 0, 0, 1);
			return;
		end
		if (m_free > 0) begin
			model_run(t, pr);
			m_free--;
			push_result(1, 0, 0, 0, 0, 0, 0, 1);
			return;
		end
		// Strict compare keeps the lowest index on a priority tie.
		for (int u = 0; u < 16; u++) begin
			if (m_state[u] == psch_pkg::ST_RUNNING &&
				(!found || m_prio[u] > m_prio[worst])) begin
				worst = u; found = 1;
			end
		end
		if (found && pr < m_prio[worst]) begin
			m_state[worst] = psch_pkg::ST_PREEMPTED;
			model_run(t, pr);
			push_result(1, 0, 0, 1, worst[3:0], 0, 0, 1);
		end else begin
			push_result(0, 0, 0, 0, 0, 0, 0, 1);
		end
	endfunction

	function automatic void model_tick_end();
		logic [15:0] bits [4];
		logic [15:0] sp, ap, ex;
		bit sfire, afire, started, fin;
		int t;
		sp = (m_sens == 0) ? 16'd1 : m_sens;
		ap = (m_act == 0) ? 16'd1 : m_act;
		sfire = (m_steps % sp) == 0;
		afire = (m_steps % ap) == 0;
		for (int v = 0; v < 4; v++) begin
			bits[v] = '0;
			if (sfire) begin
				bits[v][2:0] = 3'b111;
				if (!m_nact[v]) begin
					m_nact[v] = 1; m_nrem[v] = m_sc;
				end
			end
			if (m_npulse[v]) bits[v][3] = 1'b1;
			for (int k = 0; k < 4; k++) begin
				ex = exec_ticks(k);
				t = v*4 + k;
				started = m_state[t] == psch_pkg::ST_RUNNING && m_remain[t] == ex;
				fin = m_state[t] == psch_pkg::ST_COMPLETED;
				if (started || (fin && ex == 0)) bits[v][4 + 2*k] = 1'b1;
				if (fin) bits[v][5 + 2*k] = 1'b1;
			end
			if (m_state[v*4 + 3] == psch_pkg::ST_COMPLETED) bits[v][12] = 1'b1;
			if (m_npulse[4 + v]) bits[v][13] = 1'b1;
			if (afire) bits[v][15:14] = 2'b11;
		end
		for (t = 0; t < 16; t++)
			if (m_state[t] == psch_pkg::ST_COMPLETED) m_state[t] = psch_pkg::ST_IDLE;
		if (m_steps != 32'hFFFF_FFFF) m_steps++;
		for (int v = 0; v < 4; v++)
			push_result(0, 0, 0, 0, 0, v[1:0], bits[v], v == 3);
	endfunction

	function automatic void model_request(logic [1:0] cmd, logic [3:0] tsk,
			logic [15:0] pr, logic [3:0] ff);
		case (cmd)
			psch_pkg::CMD_TICK_BEGIN: model_tick_begin(ff);
			psch_pkg::CMD_ACTIVATE: model_activate(tsk, pr);
			psch_pkg::CMD_TICK_END: model_tick_end();
			default: ;
		endcase
	endfunction

	// Result checker: every strobe is compared with the oldest expectation.
	always @(posedge clk) begin
		sched_result_t got, want;
		if (arst_n && done) begin
			got.ok = ok; got.released = released_mask; got.completed = completed_mask;
			got.pv = preempt_valid; got.pt = preempted_task; got.veh = vehicle;
			got.trig = trigger_bits; got.last = last; got.states = task_states;
			got.free = free_cores;
			results_seen++;
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result %p", got);
			end else begin
				want = pending_results.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected %p, got %p", want, got);
				end
			end
		end
	end

	// Watchdog on cycles in which neither a request nor a result is taken.
	always @(posedge clk) begin
		if (done || item_taken) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	// Pause on the request side; mostly short, a few long.
	task automatic request_gap();
		int n;
		int r;
		r = $urandom_range(99);
		if (r < 60) n = 0;
		else if (r < 95) n = $urandom_range(5, 1);
		else n = $urandom_range(60, 20);
		if (n > 0) begin
			start <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	// Presents one request and waits until it is taken.
	task automatic send_request(logic [1:0] cmd, logic [3:0] tsk, logic [15:0] pr,
			logic [3:0] ff);
		command <= cmd; task_req <= tsk; priority_req <= pr; ff_ref_mask <= ff;
		start <= 1'b1;
		item_taken = 1'b0;
		forever begin
			@(posedge clk);
			if (!busy) break;
		end
		item_taken = 1'b1;
		items_sent++;
		model_request(cmd, tsk, pr, ff);
	endtask

	task automatic drain_results();
		start <= 1'b0;
		item_taken = 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Write enable stays high over a run of writes; the caller lowers it.
	task automatic write_reg(logic [2:0] idx, logic [63:0] val);
		cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
		@(posedge clk);
		model_write(idx, val);
	endtask

	function automatic logic [15:0] random_prio();
		return ($urandom_range(3) == 0) ? 16'($urandom_range(7)) : 16'($urandom);
	endfunction

	// Picks a released or preempted task most of the time, any task otherwise.
	function automatic logic [3:0] pick_task();
		int ready [$];
		for (int t = 0; t < 16; t++)
			if (m_state[t] == psch_pkg::ST_RELEASED || m_state[t] == psch_pkg::ST_PREEMPTED)
				ready.insert(ready.size(), t);
		if (ready.size() > 0 && $urandom_range(9) < 8)
			return ready[$urandom_range(ready.size() - 1)];
		return 4'($urandom);
	endfunction

	// One scheduling tick with random content, now and then broken or noisy.
	task automatic random_tick();
		int acts;
		if ($urandom_range(9) != 0)
			send_request(psch_pkg::CMD_TICK_BEGIN, 4'($urandom), 16'($urandom),
				4'($urandom));
		request_gap();
		acts = $urandom_range(4);
		for (int a = 0; a < acts; a++) begin
			if ($urandom_range(19) == 0)
				send_request(CMD_UNUSED, 4'($urandom), 16'($urandom), 4'($urandom));
			else
				send_request(psch_pkg::CMD_ACTIVATE, pick_task(), random_prio(),
					4'($urandom));
			request_gap();
		end
		if ($urandom_range(9) != 0)
			send_request(psch_pkg::CMD_TICK_END, 4'($urandom), 16'($urandom),
				4'($urandom));
		request_gap();
	endtask

	task automatic random_phase(int n);
		int start_count;
		start_count = items_sent;
		while (items_sent - start_count < n) random_tick();
	endtask

	function automatic logic [63:0] small_fields(int hi);
		logic [63:0] v;
		for (int k = 0; k < 4; k++) v[16*k +: 16] = 16'($urandom_range(hi));
		return v;
	endfunction

	function automatic sched_result_t typed_single(logic okv, logic [47:0] st, logic [4:0] fr);
		sched_result_t r;
		r = '0;
		r.ok = okv; r.last = 1'b1; r.states = st; r.free = fr;
		return r;
	endfunction

	plan_row_t plan [$];

	task automatic add_row(logic [1:0] cmd, logic [3:0] tsk, logic [15:0] pr,
			logic [3:0] ff, bit typed, sched_result_t want);
		plan_row_t row;
		row.cmd = cmd; row.tsk = tsk; row.prio = pr; row.ff = ff;
		row.typed = typed; row.want = want;
		plan.insert(plan.size(), row);
	endtask

	initial begin
		model_reset();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part, in reset configuration: zero run times, two cores.
		add_row(psch_pkg::CMD_ACTIVATE, 4'd0, 16'd5, 4'd0, 1, typed_single(0, '0, 5'd2));
		add_row(psch_pkg::CMD_TICK_BEGIN, 4'd0, 16'd0, 4'hF, 0, '0);
		add_row(psch_pkg::CMD_ACTIVATE, 4'd2, 16'd0, 4'd0, 0, '0);
		add_row(psch_pkg::CMD_ACTIVATE, 4'd3, 16'hFFFF, 4'd0, 0, '0);
		add_row(psch_pkg::CMD_ACTIVATE, 4'd6, 16'd100, 4'd0, 0, '0);
		add_row(psch_pkg::CMD_ACTIVATE, 4'd7, 16'hFFFF, 4'd0, 0, '0);
		add_row(psch_pkg::CMD_ACTIVATE, 4'd2, 16'd0, 4'd0, 0, '0);
		add_row(psch_pkg::CMD_TICK_BEGIN, 4'd0, 16'd0, 4'd0, 0, '0);
		add_row(psch_pkg::CMD_TICK_END, 4'd0, 16'd0, 4'd0, 0, '0);
		add_row(CMD_UNUSED, 4'hF, 16'hFFFF, 4'hF, 0, '0);
		add_row(psch_pkg::CMD_ACTIVATE, 4'd3, 16'd7, 4'd0, 0, '0);
		add_row(psch_pkg::CMD_ACTIVATE, 4'd15, 16'd0, 4'd0, 0, '0);
		add_row(psch_pkg::CMD_TICK_BEGIN, 4'd0, 16'd0, 4'hA, 0, '0);
		add_row(psch_pkg::CMD_TICK_END, 4'd0, 16'd0, 4'd0, 0, '0);
		add_row(psch_pkg::CMD_TICK_BEGIN, 4'd0, 16'd0, 4'h5, 0, '0);
		add_row(psch_pkg::CMD_TICK_END, 4'd0, 16'd0, 4'd0, 0, '0);
		foreach (plan[i]) begin
			send_request(plan[i].cmd, plan[i].tsk, plan[i].prio, plan[i].ff);
			if (plan[i].typed) begin
				pending_results[pending_results.size() - 1] = plan[i].want;
			end
			request_gap();
		end
		random_phase(15);

		// Short run times and periods on a single core; hold off until all is out.
		drain_results();
		write_reg(psch_pkg::REG_EXEC, small_fields(4));
		write_reg(psch_pkg::REG_PERIOD, small_fields(5));
		write_reg(psch_pkg::REG_SC_DELAY, 64'd2);
		write_reg(psch_pkg::REG_CA_DELAY, 64'd3);
		write_reg(psch_pkg::REG_CORES, 64'd1);
		write_reg(psch_pkg::REG_SENSOR, 64'd2);
		write_reg(psch_pkg::REG_ACTUATOR, 64'd3);
		cfg_we <= 1'b0;
		@(posedge clk);
		random_phase(35);

		// Widest extremes: sixteen cores, zero delays and sensor period.
		drain_results();
		write_reg(psch_pkg::REG_CORES, 64'd16);
		write_reg(psch_pkg::REG_SC_DELAY, 64'd0);
		write_reg(psch_pkg::REG_CA_DELAY, 64'd0);
		write_reg(psch_pkg::REG_SENSOR, 64'd0);
		write_reg(psch_pkg::REG_ACTUATOR, 64'hFFFF);
		write_reg(psch_pkg::REG_EXEC, {16'hFFFF, 16'd0, 16'd1, 16'd2});
		write_reg(psch_pkg::REG_PERIOD, {16'd0, 16'hFFFF, 16'd1, 16'd3});
		cfg_we <= 1'b0;
		@(posedge clk);
		random_phase(30);

		// A long sensor delay, full-range random timing, then a run length already passed.
		drain_results();
		write_reg(psch_pkg::REG_SC_DELAY, 64'hFFFF);
		write_reg(psch_pkg::REG_CA_DELAY, 64'd1);
		write_reg(psch_pkg::REG_SENSOR, 64'hFFFF);
		write_reg(psch_pkg::REG_ACTUATOR, 64'd0);
		write_reg(psch_pkg::REG_EXEC, {$urandom, $urandom});
		write_reg(psch_pkg::REG_PERIOD, {$urandom, $urandom});
		write_reg(psch_pkg::REG_CORES, 64'd3);
		write_reg(psch_pkg::REG_RUN_LEN, 64'hFFFF_FFFF);
		cfg_we <= 1'b0;
		@(posedge clk);
		random_phase(15);
		drain_results();
		write_reg(psch_pkg::REG_RUN_LEN, 64'd1);
		cfg_we <= 1'b0;
		@(posedge clk);
		random_phase(10);

		drain_results();
		$display("Covered %0d requests and %0d results over five register settings,",
			items_sent, results_seen);
		$display("including preemption, feedforward release and the finished run.");
		if (mismatches == 0) begin
			$display("end of test: clean");
		end else begin
			$display("%0d mismatches, %0d expectations left", mismatches,
				pending_results.size());
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule

`default_nettype wire
